>>> rtl/nds_pkg.sv
// Package for the night dimming scheduler: shared constants, codes,
// payload and configuration structs, and the sequencer state type.
// No dependencies.
package nds_pkg;

    localparam int unsigned DAY_SECONDS = 86400;
    localparam int DIV_W = 17;
    localparam logic [DIV_W-1:0] DAY_C = DIV_W'(DAY_SECONDS);
    // a day is 675 * 2^7 seconds; floor(2^40 / 675) estimates the day count
    localparam int DAY_POW2 = 7;
    localparam logic [30:0] DAY_RECIP = 31'd1628906115;
    localparam logic [16:0] FULL_LEVEL = 17'h10000;
    localparam int CNT_W = 5;
    localparam int FADE_STEPS = 16;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 17;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MODE,
        CFG_START,
        CFG_END,
        CFG_FADE,
        CFG_DAY_BRT,
        CFG_NIGHT_BRT
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic        time_valid;
        logic        force_recompute;
    } t_in_item;

    typedef struct packed {
        logic        night_active;
        logic [16:0] fade_level;
        logic [15:0] output_brightness;
    } t_out_item;

    typedef struct packed {
        logic        mode_enabled;
        logic [16:0] night_start_offset;
        logic [16:0] night_end_offset;
        logic [16:0] fade_interval;
        logic [15:0] day_brightness;
        logic [15:0] night_brightness;
    } t_cfg;

    typedef struct packed {
        logic in_ready;
        logic res_valid;
    } t_seq_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_DAY,
        S_DFIX,
        S_TAIL,
        S_WRAP,
        S_WIN,
        S_WIN2,
        S_EVAL,
        S_FADE,
        S_RAMP,
        S_DIV,
        S_MUL,
        S_MIX,
        S_DONE
    } t_state;

endpackage

>>> rtl/night_dimming_scheduler_unit.sv
// Night dimming scheduler top level: configuration registers, output register.
// Depends on nds_pkg and nds_seq.
//
// One tick in, one result out. A tick is shortest when the block is
// disabled or time is invalid, longer inside the fade ramp, and longest
// when the window is derived: the day start comes from a reciprocal
// multiply with one correction step, and the 16-step fade quotient runs
// one bit a cycle through a single shared restoring-division
// step; the input is not ready while a tick is in work, and a finished tick
// waits further while the output register still holds an unread result.
// Results sit in an output register, so the next tick is taken while one
// still waits. Configuration writes land at once and must come while idle;
// they do not mark the window stale, so send a tick with force_recompute.
module night_dimming_scheduler_unit
    import nds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_seq_ctl  seq_ctl;
    t_out_item seq_res;
    logic      out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MODE:      r_cfg.mode_enabled       <= i_cfg_wdata[0];
                CFG_START:     r_cfg.night_start_offset <= i_cfg_wdata;
                CFG_END:       r_cfg.night_end_offset   <= i_cfg_wdata;
                CFG_FADE:      r_cfg.fade_interval      <= i_cfg_wdata;
                CFG_DAY_BRT:   r_cfg.day_brightness     <= i_cfg_wdata[15:0];
                CFG_NIGHT_BRT: r_cfg.night_brightness   <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    nds_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_out_free (out_free),
        .o_ctl      (seq_ctl),
        .o_res      (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_ctl.res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load a finished transaction only when the slot is free
    always_ff @(posedge i_clk) begin
        if (seq_ctl.res_valid && out_free) begin
            r_out_data <= seq_res;
        end
    end

    assign o_in_ready  = seq_ctl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/nds_div_step.sv
// One restoring-division step, used over and over for the fade quotient.
// Depends on nds_pkg.
module nds_div_step
    import nds_pkg::*;
(
    input  logic [DIV_W-1:0] i_rem,
    input  logic             i_bit,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_ge,
    output logic [DIV_W-1:0] o_rem
);

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;

    always_comb begin
        trial = {i_rem, i_bit};
        diff  = trial - {1'b0, i_divisor};
        o_ge  = trial >= {1'b0, i_divisor};
        // remainder stays below the divisor, so the top bit drops
        o_rem = o_ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

endmodule

>>> rtl/nds_seq.sv
// Sequencer and datapath: window derivation, fade ramp and brightness blend.
// Depends on nds_pkg and nds_div_step.
module nds_seq
    import nds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    input  logic      i_out_free,
    output t_seq_ctl  o_ctl,
    output t_out_item o_res
);

    t_state r_state, n_state;
    logic   r_stale, n_stale;
    logic   r_in_night, n_in_night;
    logic [31:0] r_fis, n_fis;
    logic [31:0] r_fns, n_fns;
    logic [31:0] r_fne, n_fne;
    logic [31:0] r_foe, n_foe;
    logic [16:0] r_fade, n_fade;
    logic   r_post, n_post;
    logic   r_derived, n_derived;

    logic [31:0] r_now, n_now;
    logic [15:0] r_qday, n_qday;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [FADE_STEPS-1:0] r_q, n_q;
    logic [31:0] r_day, n_day;
    logic [31:0] r_tail, n_tail;
    logic [31:0] r_span, n_span;
    logic signed [34:0] r_prod, n_prod;
    logic [15:0] r_mix, n_mix;

    logic [DIV_W-1:0] du_rem;
    logic             du_bit;
    logic [DIV_W-1:0] du_div;
    logic             du_ge;
    logic [DIV_W-1:0] du_rem_out;

    logic [16:0] start_c;
    logic [16:0] end_c;
    logic signed [16:0] brt_diff;
    logic signed [17:0] lvl;
    logic signed [34:0] prod_full;
    logic signed [34:0] prod_sh;
    logic [17:0] mix_sum;
    logic [55:0] recip_prod;

    nds_div_step u_div_step (
        .i_rem     (du_rem),
        .i_bit     (du_bit),
        .i_divisor (du_div),
        .o_ge      (du_ge),
        .o_rem     (du_rem_out)
    );

    always_comb begin
        du_rem = r_rem;
        du_bit = 1'b0;
        du_div = i_cfg.fade_interval;
    end

    always_comb begin
        start_c = (i_cfg.night_start_offset < DAY_C) ? i_cfg.night_start_offset : DAY_C;
        end_c   = (i_cfg.night_end_offset < DAY_C) ? i_cfg.night_end_offset : DAY_C;
        brt_diff = $signed({1'b0, i_cfg.night_brightness}) - $signed({1'b0, i_cfg.day_brightness});
        lvl      = $signed({1'b0, r_fade});
        prod_full = 35'(brt_diff) * 35'(lvl);
        prod_sh   = r_prod >>> 16;
        mix_sum   = {2'b00, i_cfg.day_brightness} + prod_sh[17:0];
        // day count estimate, low by at most one
        recip_prod = 56'(r_now[31:DAY_POW2]) * 56'(DAY_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_stale    <= 1'b1;
            r_in_night <= 1'b0;
            r_fis      <= '0;
            r_fns      <= '0;
            r_fne      <= '0;
            r_foe      <= '0;
            r_fade     <= '0;
            r_post     <= 1'b0;
            r_derived  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_stale    <= n_stale;
            r_in_night <= n_in_night;
            r_fis      <= n_fis;
            r_fns      <= n_fns;
            r_fne      <= n_fne;
            r_foe      <= n_foe;
            r_fade     <= n_fade;
            r_post     <= n_post;
            r_derived  <= n_derived;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now  <= n_now;
        r_qday <= n_qday;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_day  <= n_day;
        r_tail <= n_tail;
        r_span <= n_span;
        r_prod <= n_prod;
        r_mix  <= n_mix;
    end

    always_comb begin
        n_state    = r_state;
        n_stale    = r_stale;
        n_in_night = r_in_night;
        n_fis      = r_fis;
        n_fns      = r_fns;
        n_fne      = r_fne;
        n_foe      = r_foe;
        n_fade     = r_fade;
        n_post     = r_post;
        n_derived  = r_derived;
        n_now      = r_now;
        n_qday     = r_qday;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_q        = r_q;
        n_day      = r_day;
        n_tail     = r_tail;
        n_span     = r_span;
        n_prod     = r_prod;
        n_mix      = r_mix;
        o_ctl.in_ready  = 1'b0;
        o_ctl.res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_now     = i_in_data.now_seconds;
                    n_derived = 1'b0;
                    n_post    = 1'b0;
                    if (i_cfg.mode_enabled && i_in_data.time_valid) begin
                        if (r_stale || i_in_data.force_recompute) begin
                            n_stale = 1'b1;
                            n_state = S_MOD;
                        end else begin
                            n_state = S_EVAL;
                        end
                    end else begin
                        // frozen: report the held state
                        n_state = S_MUL;
                    end
                end
            end
            S_MOD: begin
                n_qday  = recip_prod[55:40];
                n_state = S_DAY;
            end
            S_DAY: begin
                n_day   = 32'(r_qday) * DAY_SECONDS;
                n_state = S_DFIX;
            end
            S_DFIX: begin
                // estimate one day short: advance to the true day start
                if ((r_now - r_day) >= DAY_SECONDS) begin
                    n_day = r_day + {{(32-DIV_W){1'b0}}, DAY_C};
                end
                n_state = S_TAIL;
            end
            S_TAIL: begin
                n_tail  = r_day + {15'b0, end_c} + {15'b0, i_cfg.fade_interval};
                n_state = S_WRAP;
            end
            S_WRAP: begin
                // past the fade-out end: move to the next day
                if (r_now > r_tail) begin
                    n_day  = r_day + {{(32-DIV_W){1'b0}}, DAY_C};
                    n_tail = r_tail + {{(32-DIV_W){1'b0}}, DAY_C};
                end
                n_state = S_WIN;
            end
            S_WIN: begin
                n_fns = r_day + {15'b0, start_c}
                        - ((start_c > end_c) ? {{(32-DIV_W){1'b0}}, DAY_C} : 32'd0);
                n_foe = r_tail;
                n_fne = r_tail - {15'b0, i_cfg.fade_interval};
                n_state = S_WIN2;
            end
            S_WIN2: begin
                n_fis     = r_fns - {15'b0, i_cfg.fade_interval};
                n_stale   = 1'b0;
                n_derived = 1'b1;
                n_state   = r_post ? S_MUL : S_EVAL;
            end
            S_EVAL: begin
                n_in_night = (r_now >= r_fis) && (r_now <= r_foe);
                if ((r_now >= r_fis) && (r_now <= r_foe)) begin
                    n_state = S_FADE;
                end else if ((r_now > r_fis) && !r_derived) begin
                    n_post  = 1'b1;
                    n_state = S_MOD;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_FADE: begin
                if (r_now < r_fns) begin
                    n_span  = r_now - r_fis;
                    n_state = S_RAMP;
                end else if (r_now < r_fne) begin
                    n_fade  = FULL_LEVEL;
                    n_state = S_MUL;
                end else if (r_now < r_foe) begin
                    n_span  = r_foe - r_now;
                    n_state = S_RAMP;
                end else begin
                    n_fade  = '0;
                    n_state = S_MUL;
                end
            end
            S_RAMP: begin
                // zero interval or overrun saturates at full night
                if ((i_cfg.fade_interval == '0) ||
                    (r_span >= {15'b0, i_cfg.fade_interval})) begin
                    n_fade  = FULL_LEVEL;
                    n_state = S_MUL;
                end else begin
                    n_rem   = r_span[DIV_W-1:0];
                    n_cnt   = '0;
                    n_q     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = du_rem_out;
                n_q   = {r_q[FADE_STEPS-2:0], du_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FADE_STEPS - 1)) begin
                    n_fade  = {1'b0, r_q[FADE_STEPS-2:0], du_ge};
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = prod_full;
                n_state = S_MIX;
            end
            S_MIX: begin
                n_mix   = r_in_night ? mix_sum[15:0] : 16'd0;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_ctl.res_valid = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.night_active      = r_in_night;
        o_res.fade_level        = r_fade;
        o_res.output_brightness = r_mix;
    end

endmodule

>>> rtl/nds_checker.sv
// Port-level checks for the night dimming scheduler, bound to the top level.
// Depends on nds_pkg and night_dimming_scheduler_unit.
module nds_checker
    import nds_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_dark_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.night_active) |-> (o_out_data.output_brightness == 16'd0))
        else $error("brightness nonzero outside the night window");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.fade_level <= FULL_LEVEL))
        else $error("fade level above full night");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind night_dimming_scheduler_unit nds_checker u_nds_checker (.*);

>>> bench/night_dimming_scheduler_unit_tb.sv
// Testbench for night_dimming_scheduler_unit: random and directed time ticks,
// cycle-free prediction of the night window, fade level and brightness.
// Depends on nds_pkg and the night_dimming_scheduler_unit RTL.
module night_dimming_scheduler_unit_tb;
    import nds_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam logic [CFG_AW-1:0] CFG_SPARE_LO = CFG_AW'(CFG_NIGHT_BRT) + 1'b1;
    localparam logic [CFG_AW-1:0] CFG_SPARE_HI = '1;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;

    night_dimming_scheduler_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor copy of configuration and window state
    t_cfg        cfg_now = '0;
    logic        win_stale = 1'b1;
    logic        night_on = 1'b0;
    logic [31:0] ramp_up_at = '0;
    logic [31:0] full_on_at = '0;
    logic [31:0] full_off_at = '0;
    logic [31:0] ramp_down_end = '0;
    logic [16:0] fade_q = '0;

    t_in_item  tick_queue[$];
    t_out_item pending_dim_results[$];

    int  in_idle_pct = 22;
    int  out_idle_pct = 22;
    int  mismatches = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    bit  in_took = 1'b0;

    function automatic logic [16:0] ramp_level(logic [31:0] span);
        logic [63:0] prod;
        if (cfg_now.fade_interval == '0 || span >= 32'(cfg_now.fade_interval))
            return FULL_LEVEL;
        prod = ({32'b0, span} << 16) / 64'(cfg_now.fade_interval);
        return prod[16:0];
    endfunction

    function automatic void derive_window_at(logic [31:0] now_s);
        logic [31:0] s_off;
        logic [31:0] e_off;
        logic [31:0] day0;
        logic [31:0] tail;
        s_off = (cfg_now.night_start_offset < DAY_C) ? 32'(cfg_now.night_start_offset)
                                                     : DAY_SECONDS;
        e_off = (cfg_now.night_end_offset < DAY_C) ? 32'(cfg_now.night_end_offset)
                                                   : DAY_SECONDS;
        day0 = now_s - (now_s % DAY_SECONDS);
        tail = day0 + e_off + 32'(cfg_now.fade_interval);
        if (now_s > tail) begin
            day0 += DAY_SECONDS;
            tail += DAY_SECONDS;
        end
        full_on_at = day0 + s_off;
        // start after end means the night began on the previous day
        if (s_off > e_off)
            full_on_at -= DAY_SECONDS;
        ramp_up_at = full_on_at - 32'(cfg_now.fade_interval);
        full_off_at = tail - 32'(cfg_now.fade_interval);
        ramp_down_end = tail;
    endfunction

    function automatic t_out_item dim_predict(t_in_item tk);
        logic [31:0] now_s;
        logic [16:0] lvl;
        logic [63:0] mix;
        t_out_item   r;
        now_s = tk.now_seconds;
        if (cfg_now.mode_enabled && tk.time_valid) begin
            if (tk.force_recompute)
                win_stale = 1'b1;
            if (win_stale) begin
                derive_window_at(now_s);
                win_stale = 1'b0;
            end
            night_on = (now_s >= ramp_up_at) && (now_s <= ramp_down_end);
            if (night_on) begin
                if (now_s < full_on_at)
                    fade_q = ramp_level(now_s - ramp_up_at);
                else if (now_s < full_off_at)
                    fade_q = FULL_LEVEL;
                else if (now_s < ramp_down_end)
                    fade_q = ramp_level(ramp_down_end - now_s);
                else
                    fade_q = '0;
            end else if (now_s > ramp_up_at) begin
                derive_window_at(now_s);
            end
        end
        lvl = (fade_q > FULL_LEVEL) ? FULL_LEVEL : fade_q;
        mix = '0;
        if (night_on)
            mix = (64'(cfg_now.day_brightness) * (64'(FULL_LEVEL) - 64'(lvl)) +
                   64'(cfg_now.night_brightness) * 64'(lvl)) >> 16;
        r.night_active = night_on;
        r.fade_level = fade_q;
        r.output_brightness = mix[15:0];
        return r;
    endfunction

    // Driver: change inputs on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_took) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= tick_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Monitor, scoreboard and watchdog on the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                results_seen++;
                if (pending_dim_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    want = pending_dim_results.pop_front();
                    if (o_out_data.night_active !== want.night_active ||
                        o_out_data.fade_level !== want.fade_level ||
                        o_out_data.output_brightness !== want.output_brightness) begin
                        mismatches++;
                        // night / fade / brightness
                        if (mismatches <= SHOWN_MISMATCHES)
                            $display("result %0d: expected %0b/%0d/%0d got %0b/%0d/%0d",
                                     results_seen, want.night_active, want.fade_level,
                                     want.output_brightness, o_out_data.night_active,
                                     o_out_data.fade_level, o_out_data.output_brightness);
                    end
                end
            end
            in_took = i_in_valid && o_in_ready;
            if (in_took) begin
                moved = 1'b1;
                pending_dim_results.push_back(dim_predict(i_in_data));
            end
            if (i_cfg_we)
                moved = 1'b1;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (addr)
            CFG_MODE:      cfg_now.mode_enabled = val[0];
            CFG_START:     cfg_now.night_start_offset = val;
            CFG_END:       cfg_now.night_end_offset = val;
            CFG_FADE:      cfg_now.fade_interval = val;
            CFG_DAY_BRT:   cfg_now.day_brightness = val[15:0];
            CFG_NIGHT_BRT: cfg_now.night_brightness = val[15:0];
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold until every tick is answered, then let the block settle
    task automatic drain();
        while (tick_queue.size() != 0 || i_in_valid || pending_dim_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_tick(logic [31:0] n, logic v, logic f);
        t_in_item tk;
        tk.now_seconds = n;
        tk.time_valid = v;
        tk.force_recompute = f;
        tick_queue.push_back(tk);
    endtask

    // Walk forward in time from just before a fade-in or a fade-out
    task automatic add_walk(int n);
        logic [31:0] t;
        logic [31:0] base;
        logic [31:0] s_off;
        logic [31:0] e_off;
        int          cap;
        base = $urandom();
        if ($urandom_range(9) == 0)
            base = 32'hFFFF_FFFF - $urandom_range(0, 3 * DAY_SECONDS);
        s_off = (cfg_now.night_start_offset < DAY_C) ? 32'(cfg_now.night_start_offset)
                                                     : DAY_SECONDS;
        e_off = (cfg_now.night_end_offset < DAY_C) ? 32'(cfg_now.night_end_offset)
                                                   : DAY_SECONDS;
        case ($urandom_range(5))
            0: cap = 1;
            1: cap = 30;
            2: cap = 300;
            3: cap = int'(cfg_now.fade_interval) / 8 + 1;
            4: cap = 3000;
            default: cap = 20000;
        endcase
        t = base - (base % DAY_SECONDS) - $urandom_range(0, 4 * cap);
        if ($urandom_range(1) == 0)
            t += s_off - 32'(cfg_now.fade_interval);
        else
            t += e_off;
        add_tick(t, 1'b1, $urandom_range(99) < 60);
        repeat (n - 1) begin
            t += $urandom_range(1, cap);
            add_tick(t, $urandom_range(99) >= 3, $urandom_range(99) < 3);
        end
    endtask

    task automatic fill_phase(int n);
        int made;
        int len;
        made = 0;
        while (made < n) begin
            if ($urandom_range(9) < 8) begin
                len = $urandom_range(10, 40);
                if (len > n - made)
                    len = n - made;
                add_walk(len);
            end else begin
                len = $urandom_range(1, 5);
                if (len > n - made)
                    len = n - made;
                repeat (len)
                    add_tick($urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            made += len;
        end
    endtask

    task automatic load_setting(int k);
        case (k)
            0: begin
                cfg_write(CFG_MODE, 17'd1);
                cfg_write(CFG_START, 17'd0);
                cfg_write(CFG_END, 17'(DAY_SECONDS));
                cfg_write(CFG_FADE, 17'd0);
                cfg_write(CFG_DAY_BRT, 17'd65535);
                cfg_write(CFG_NIGHT_BRT, 17'd0);
            end
            1: begin
                cfg_write(CFG_START, 17'(DAY_SECONDS));
                cfg_write(CFG_END, 17'd0);
                cfg_write(CFG_FADE, 17'h1FFFF);
                cfg_write(CFG_DAY_BRT, 17'h10000);
                cfg_write(CFG_NIGHT_BRT, 17'h1FFFF);
            end
            2: begin
                cfg_write(CFG_MODE, {16'($urandom()), 1'b0});
                cfg_write(CFG_SPARE_LO, 17'($urandom()));
                cfg_write(CFG_SPARE_HI, 17'($urandom()));
                cfg_write(CFG_FADE, 17'($urandom_range(1, 7200)));
            end
            3: begin
                cfg_write(CFG_MODE, {16'($urandom()), 1'b1});
                cfg_write(CFG_START, 17'h1FFFF);
                cfg_write(CFG_END, 17'h1FFFF);
                cfg_write(CFG_FADE, 17'd3600);
                cfg_write(CFG_DAY_BRT, 17'($urandom()));
                cfg_write(CFG_NIGHT_BRT, 17'($urandom()));
            end
            default: begin
                cfg_write(CFG_START, 17'($urandom_range(0, DAY_SECONDS)));
                cfg_write(CFG_END, 17'($urandom_range(0, DAY_SECONDS)));
                // leave the interval alone now and then so old windows overrun
                if (k != 6)
                    cfg_write(CFG_FADE, 17'($urandom_range(1, 7200)));
                cfg_write(CFG_DAY_BRT, 17'($urandom()));
                cfg_write(CFG_NIGHT_BRT, 17'($urandom()));
            end
        endcase
        cfg_done();
    endtask

    initial begin
        logic [31:0] d0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset: ticks must leave the state alone
        add_tick(32'd0, 1'b1, 1'b1);
        add_tick(32'hFFFF_FFFF, 1'b1, 1'b0);
        add_tick(32'h5A5A_A5A5, 1'b0, 1'b1);
        drain();

        // night wraps midnight: 22:00 to 06:00 with a half-hour fade
        cfg_write(CFG_MODE, 17'd1);
        cfg_write(CFG_START, 17'd79200);
        cfg_write(CFG_END, 17'd21600);
        cfg_write(CFG_FADE, 17'd1800);
        cfg_write(CFG_DAY_BRT, 17'd50000);
        cfg_write(CFG_NIGHT_BRT, 17'd10000);
        cfg_done();
        d0 = 32'd1_728_000_000;
        add_tick(d0 + 32'd70000, 1'b1, 1'b1);
        add_tick(d0 + 32'd77400, 1'b1, 1'b0);
        add_tick(d0 + 32'd78300, 1'b1, 1'b0);
        add_tick(d0 + 32'd79200, 1'b1, 1'b0);
        add_tick(d0 + 32'd90000, 1'b1, 1'b0);
        add_tick(d0 + 32'd108000, 1'b1, 1'b0);
        add_tick(d0 + 32'd108900, 1'b1, 1'b0);
        add_tick(d0 + 32'd109800, 1'b0, 1'b1);
        add_tick(d0 + 32'd109800, 1'b1, 1'b0);
        add_tick(d0 + 32'd109801, 1'b1, 1'b0);
        add_tick(d0 + 32'd50000, 1'b1, 1'b0);
        add_tick(32'd0, 1'b1, 1'b1);
        add_tick(32'd0, 1'b1, 1'b0);
        add_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
        drain();

        for (int k = 0; k < 9; k++) begin
            load_setting(k);
            in_idle_pct = (k == 5) ? 0 : 22;
            out_idle_pct = (k == 5) ? 0 : 22;
            fill_phase((k == 2) ? 40 : 189);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_dim_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
